FILE: src/ltgr_pkg.sv
// Shared constants and codes for the Liberty token grammar recognizer.
package ltgr_pkg;

	localparam int QUEUE_DEPTH = 16;
	localparam int MAX_NEST    = 32;
	localparam int REF_W       = 16;
	localparam int KIND_W      = 4;
	localparam int EV_W        = 4;
	localparam int LVL_W       = 6;

	localparam int QIDX_W = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam int NEST_W = $clog2(MAX_NEST + 1);

	localparam int DEFINE_ARGS       = 3;
	localparam int SIMPLE_GROUP_ARGS = 2;

	// token kinds
	localparam logic [KIND_W-1:0] K_CBLOCK = 4'd0;
	localparam logic [KIND_W-1:0] K_CLINE  = 4'd1;
	localparam logic [KIND_W-1:0] K_SEMI   = 4'd2;
	localparam logic [KIND_W-1:0] K_EXPR   = 4'd3;
	localparam logic [KIND_W-1:0] K_QUOTED = 4'd4;
	localparam logic [KIND_W-1:0] K_DEFINE = 4'd5;
	localparam logic [KIND_W-1:0] K_LCURLY = 4'd6;
	localparam logic [KIND_W-1:0] K_RCURLY = 4'd7;
	localparam logic [KIND_W-1:0] K_LPAREN = 4'd8;
	localparam logic [KIND_W-1:0] K_RPAREN = 4'd9;
	localparam logic [KIND_W-1:0] K_COLON  = 4'd10;
	localparam logic [KIND_W-1:0] K_COMMA  = 4'd11;
	localparam logic [KIND_W-1:0] K_END    = 4'd12;

	// result events
	localparam logic [EV_W-1:0] EV_CONSUMED = 4'd0;
	localparam logic [EV_W-1:0] EV_SATTR    = 4'd1;
	localparam logic [EV_W-1:0] EV_CATTR    = 4'd2;
	localparam logic [EV_W-1:0] EV_SGROUP   = 4'd3;
	localparam logic [EV_W-1:0] EV_CGROUP   = 4'd4;
	localparam logic [EV_W-1:0] EV_AGROUP   = 4'd5;
	localparam logic [EV_W-1:0] EV_DEFINE   = 4'd6;
	localparam logic [EV_W-1:0] EV_CLOSE    = 4'd7;
	localparam logic [EV_W-1:0] EV_DONE     = 4'd8;
	localparam logic [EV_W-1:0] EV_ERROR    = 4'd9;
	localparam logic [EV_W-1:0] EV_STOPPED  = 4'd10;
	localparam logic [EV_W-1:0] EV_VALUE    = 4'd11;

endpackage

FILE: src/ltgr_if.sv
// Token and result channel interfaces.
interface ltgr_tok_if;
	logic                         valid;
	logic                         ready;
	logic [ltgr_pkg::KIND_W-1:0]  token_kind;
	logic [ltgr_pkg::REF_W-1:0]   token_ref;

	modport source (output valid, output token_kind, output token_ref, input ready);
	modport sink   (input valid, input token_kind, input token_ref, output ready);
endinterface

interface ltgr_res_if;
	logic                         valid;
	logic                         ready;
	logic [ltgr_pkg::EV_W-1:0]    event_res;
	logic [ltgr_pkg::REF_W-1:0]   ref_res;
	logic [ltgr_pkg::LVL_W-1:0]   nest_level;
	logic                         last;

	modport source (output valid, output event_res, output ref_res, output nest_level,
		output last, input ready);
	modport sink   (input valid, input event_res, input ref_res, input nest_level,
		input last, output ready);
endinterface

FILE: src/ltgr_queue.sv
// Pending handle queue: one write port, one read port with registered data.
module ltgr_queue (
	input  logic                        clk,
	input  logic                        we,
	input  logic [ltgr_pkg::QIDX_W-1:0] waddr,
	input  logic [ltgr_pkg::REF_W-1:0]  wdata,
	input  logic                        re,
	input  logic [ltgr_pkg::QIDX_W-1:0] raddr,
	output logic [ltgr_pkg::REF_W-1:0]  rdata
);
	import ltgr_pkg::*;

	logic [REF_W-1:0] mem [QUEUE_DEPTH];
	logic [REF_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// data holds while no read is issued
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;
endmodule

FILE: src/liberty_token_grammar_recognizer_top.sv
// Liberty token grammar recognizer: statement FSM, handle queue drain, result register.
// Usage:
//   tok (sink): one classified token per word, token_kind and token_ref.
//   res (source): result words event_res, ref_res, nest_level, last; the final
//     word caused by a token has last set.
//   A word moves on a rising clk edge with valid and ready both high.
// Sequencing:
//   Tokens that give one result word (consumed, close, done, error, stopped)
//     show that word on res the cycle after acceptance.
//   Statements that report queued handles (attributes, groups, define) read
//     the handle queue one entry at a time (read, then load), and a simple
//     attribute adds its value word last; a low res.ready holds the load.
//   The next token is taken once the output register is empty or hands its
//     word over on res in the same cycle.
// Reset: arst_n clears grammar state, queue count, depth, halt flag and the
//   output register; the queue memory is not cleared, only written entries are read.
// Stall: a low res.ready holds a valid output word and keeps tok.ready low.
// After done or an error the block halts: every token gives a single stopped
// word until reset.
module liberty_token_grammar_recognizer_top (
	input  logic       clk,
	input  logic       arst_n,
	ltgr_tok_if.sink   tok,
	ltgr_res_if.source res
);
	import ltgr_pkg::*;

	typedef enum logic [2:0] {
		ST_DEFAULT,
		ST_FIRST,
		ST_SATTR,
		ST_SATTR_END,
		ST_PAREN_BEGIN,
		ST_PAREN,
		ST_DEFINE,
		ST_PAREN_END
	} st_t;

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_RD,
		PH_WR,
		PH_TAIL
	} ph_t;

	// grammar state
	st_t               st_q;
	logic [QCNT_W-1:0] count_q;
	logic [NEST_W-1:0] nest_q;
	logic              halted_q;

	// drain sequencer
	ph_t               ph_q;
	logic [QIDX_W-1:0] idx_q;
	logic [QCNT_W-1:0] dcnt_q;
	logic [EV_W-1:0]   dev_q;
	logic              tail_q;
	logic [REF_W-1:0]  hold_ref_q;

	// output register
	logic              out_v_q;
	logic [EV_W-1:0]   out_ev_q;
	logic [REF_W-1:0]  out_ref_q;
	logic [NEST_W-1:0] out_nest_q;
	logic              out_last_q;

	logic              out_free;
	logic              acc;
	logic              is_text;
	logic              full;
	logic [REF_W-1:0]  rd_data;
	logic [QCNT_W-1:0] idx_next;
	logic              idx_final;

	// next-state decode of the accepted token
	st_t               d_st;
	logic [QCNT_W-1:0] d_cnt;
	logic [NEST_W-1:0] d_nest;
	logic              d_halt;
	logic [EV_W-1:0]   d_ev;
	logic              d_drain;
	logic              d_tail;
	logic [QCNT_W-1:0] d_dcnt;
	logic              push;
	logic              err;

	assign out_free  = !out_v_q || res.ready;
	assign tok.ready = (ph_q == PH_IDLE) && out_free;
	assign acc       = tok.valid && tok.ready;
	assign is_text   = (tok.token_kind == K_EXPR) || (tok.token_kind == K_QUOTED);
	assign full      = count_q >= QCNT_W'(QUEUE_DEPTH);
	assign idx_next  = QCNT_W'(idx_q) + QCNT_W'(1);
	assign idx_final = idx_next == dcnt_q;

	always_comb begin
		d_st    = st_q;
		d_cnt   = count_q;
		d_nest  = nest_q;
		d_halt  = halted_q;
		d_ev    = EV_CONSUMED;
		d_drain = 1'b0;
		d_tail  = 1'b0;
		d_dcnt  = count_q;
		push    = 1'b0;
		err     = 1'b0;
		if (halted_q) begin
			d_ev = EV_STOPPED;
		end else begin
			unique case (st_q)
				ST_DEFAULT: begin
					if (tok.token_kind == K_CBLOCK || tok.token_kind == K_CLINE ||
						tok.token_kind == K_SEMI) begin
						d_ev = EV_CONSUMED;
					end else if (is_text) begin
						if (full) begin
							err = 1'b1;
						end else begin
							push = 1'b1;
							d_st = ST_FIRST;
						end
					end else if (tok.token_kind == K_DEFINE) begin
						d_st = ST_DEFINE;
					end else if (tok.token_kind == K_RCURLY && nest_q != '0) begin
						d_nest = nest_q - NEST_W'(1);
						d_ev   = EV_CLOSE;
					end else if (tok.token_kind == K_RCURLY || tok.token_kind == K_END) begin
						d_halt = 1'b1;
						d_ev   = EV_DONE;
					end else begin
						err = 1'b1;
					end
				end
				ST_FIRST: begin
					if (tok.token_kind == K_LPAREN) begin
						d_st = ST_PAREN_BEGIN;
					end else if (tok.token_kind == K_COLON) begin
						d_st = ST_SATTR;
					end else begin
						err = 1'b1;
					end
				end
				ST_SATTR: begin
					if (!is_text || count_q == '0) begin
						err = 1'b1;
					end else begin
						// name from queue entry 0, value from this token
						d_drain = 1'b1;
						d_ev    = EV_SATTR;
						d_dcnt  = QCNT_W'(1);
						d_tail  = 1'b1;
						d_cnt   = '0;
						d_st    = ST_SATTR_END;
					end
				end
				ST_SATTR_END: begin
					if (tok.token_kind == K_SEMI) begin
						d_st = ST_DEFAULT;
					end else begin
						err = 1'b1;
					end
				end
				ST_PAREN_BEGIN, ST_PAREN: begin
					if (is_text) begin
						if (full) begin
							err = 1'b1;
						end else begin
							push = 1'b1;
							d_st = ST_PAREN;
						end
					end else if (tok.token_kind == K_COMMA) begin
						d_st = ST_PAREN;
					end else if (tok.token_kind == K_RPAREN) begin
						d_st = ST_PAREN_END;
					end else begin
						err = 1'b1;
					end
				end
				ST_DEFINE: begin
					if (is_text) begin
						if (full) begin
							err = 1'b1;
						end else begin
							push = 1'b1;
						end
					end else if (tok.token_kind == K_COMMA) begin
						d_ev = EV_CONSUMED;
					end else if (tok.token_kind == K_RPAREN) begin
						if (count_q != QCNT_W'(DEFINE_ARGS)) begin
							err = 1'b1;
						end else begin
							d_drain = 1'b1;
							d_ev    = EV_DEFINE;
							d_cnt   = '0;
							d_st    = ST_DEFAULT;
						end
					end else begin
						err = 1'b1;
					end
				end
				ST_PAREN_END: begin
					if (tok.token_kind == K_LCURLY) begin
						if (count_q == '0 || nest_q >= NEST_W'(MAX_NEST)) begin
							err = 1'b1;
						end else begin
							d_drain = 1'b1;
							if (count_q == QCNT_W'(1)) begin
								d_ev = EV_AGROUP;
							end else if (count_q == QCNT_W'(SIMPLE_GROUP_ARGS)) begin
								d_ev = EV_SGROUP;
							end else begin
								d_ev = EV_CGROUP;
							end
							d_nest = nest_q + NEST_W'(1);
							d_cnt  = '0;
							d_st   = ST_DEFAULT;
						end
					end else if (tok.token_kind == K_SEMI) begin
						if (count_q == '0) begin
							err = 1'b1;
						end else begin
							d_drain = 1'b1;
							d_ev    = EV_CATTR;
							d_cnt   = '0;
							d_st    = ST_DEFAULT;
						end
					end else begin
						err = 1'b1;
					end
				end
			endcase
		end
		if (push) begin
			d_cnt = count_q + QCNT_W'(1);
		end
		if (err) begin
			d_halt  = 1'b1;
			d_cnt   = '0;
			d_ev    = EV_ERROR;
			d_drain = 1'b0;
			d_tail  = 1'b0;
		end
	end

	// writes land at the accept edge; reads start in the following cycle, so no overlap
	ltgr_queue u_queue (
		.clk   (clk),
		.we    (acc && push),
		.waddr (count_q[QIDX_W-1:0]),
		.wdata (tok.token_ref),
		.re    (ph_q == PH_RD),
		.raddr (idx_q),
		.rdata (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q       <= ST_DEFAULT;
			count_q    <= '0;
			nest_q     <= '0;
			halted_q   <= 1'b0;
			ph_q       <= PH_IDLE;
			idx_q      <= '0;
			dcnt_q     <= '0;
			dev_q      <= EV_CONSUMED;
			tail_q     <= 1'b0;
			hold_ref_q <= '0;
			out_v_q    <= 1'b0;
			out_ev_q   <= EV_CONSUMED;
			out_ref_q  <= '0;
			out_nest_q <= '0;
			out_last_q <= 1'b0;
		end else begin
			if (out_v_q && res.ready) begin
				out_v_q <= 1'b0;
			end
			unique case (ph_q)
				PH_IDLE: begin
					if (acc) begin
						st_q     <= d_st;
						count_q  <= d_cnt;
						nest_q   <= d_nest;
						halted_q <= d_halt;
						if (d_drain) begin
							ph_q       <= PH_RD;
							idx_q      <= '0;
							dcnt_q     <= d_dcnt;
							dev_q      <= d_ev;
							tail_q     <= d_tail;
							hold_ref_q <= tok.token_ref;
						end else begin
							out_v_q    <= 1'b1;
							out_ev_q   <= d_ev;
							out_ref_q  <= '0;
							out_nest_q <= d_nest;
							out_last_q <= 1'b1;
						end
					end
				end
				PH_RD: begin
					ph_q <= PH_WR;
				end
				PH_WR: begin
					if (out_free) begin
						out_v_q    <= 1'b1;
						out_ev_q   <= (idx_q == '0) ? dev_q : EV_VALUE;
						out_ref_q  <= rd_data;
						out_nest_q <= nest_q;
						out_last_q <= idx_final && !tail_q;
						if (idx_final) begin
							ph_q <= tail_q ? PH_TAIL : PH_IDLE;
						end else begin
							idx_q <= idx_q + QIDX_W'(1);
							ph_q  <= PH_RD;
						end
					end
				end
				PH_TAIL: begin
					if (out_free) begin
						out_v_q    <= 1'b1;
						out_ev_q   <= EV_VALUE;
						out_ref_q  <= hold_ref_q;
						out_nest_q <= nest_q;
						out_last_q <= 1'b1;
						ph_q       <= PH_IDLE;
					end
				end
			endcase
		end
	end

	assign res.valid      = out_v_q;
	assign res.event_res  = out_ev_q;
	assign res.ref_res    = out_ref_q;
	assign res.nest_level = LVL_W'(out_nest_q);
	assign res.last       = out_last_q;

`ifndef SYNTH
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= QCNT_W'(QUEUE_DEPTH))
		else $error("queue count above depth");

	a_nest_bound: assert property (@(posedge clk) disable iff (!arst_n)
		nest_q <= NEST_W'(MAX_NEST))
		else $error("nesting depth above limit");

	a_drain_range: assert property (@(posedge clk) disable iff (!arst_n)
		(ph_q == PH_RD || ph_q == PH_WR) |-> (dcnt_q != '0 && idx_next <= dcnt_q))
		else $error("drain index out of range");

	a_halt_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		halted_q |=> halted_q)
		else $error("halt flag cleared without reset");

	a_stopped_word: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && halted_q) |=> (out_v_q && out_ev_q == EV_STOPPED && out_last_q))
		else $error("halted block did not report stopped");
`endif
endmodule
